// File: src/wlk_pkg.sv
package wlk_pkg;

    localparam int VA_W        = 48;
    localparam int PA_W        = 52;
    localparam int DATA_W      = 64;
    localparam int BASE_W      = PA_W - 12;
    localparam int LEVEL_W     = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ENT_PRESENT_BIT = 0;
    localparam int ENT_LARGE_BIT   = 7;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_1G   = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_2M   = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_LAST = 2'd3;

    localparam logic MODE_REQUEST  = 1'b0;
    localparam logic MODE_RESPONSE = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_READ_FAIL   = 2'd2;
    localparam logic [1:0] ST_UNEXPECTED  = 2'd3;

    typedef enum logic [2:0] {
        OP_READ,
        OP_DONE_1G,
        OP_DONE_2M,
        OP_DONE_4K,
        OP_NOT_PRESENT,
        OP_READ_FAIL,
        OP_UNEXPECTED
    } op_t;

    // One classified word handed from the front to the back.
    typedef struct packed {
        op_t                op;
        logic [LEVEL_W-1:0] level;
        logic [BASE_W-1:0]  base;
        logic [VA_W-1:0]    va;
    } qent_t;

    // 9-bit table index of a virtual address at a level.
    function automatic logic [8:0] level_index(input logic [VA_W-1:0] va,
                                               input logic [LEVEL_W-1:0] level);
        logic [8:0] idx;
        idx = va[20:12];
        case (level)
            LEVEL_TOP: idx = va[47:39];
            LEVEL_1G:  idx = va[38:30];
            LEVEL_2M:  idx = va[29:21];
            default:   idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// File: src/wlk_front.sv
module wlk_front
    import wlk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               mode,
    input  logic [VA_W-1:0]    virt_addr,
    input  logic [PA_W-1:0]    table_root,
    input  logic [DATA_W-1:0]  read_data,
    input  logic               read_ok,
    output qent_t              entry
);

    logic               busy_reg;
    logic               busy_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [VA_W-1:0]    va_reg;
    logic [VA_W-1:0]    va_next;
    logic               present;
    logic               huge_page;

    assign present   = read_data[ENT_PRESENT_BIT];
    assign huge_page = read_data[ENT_LARGE_BIT];

    // Classify the word against the walk state and work out the state it leaves.
    always_comb
    begin
        busy_next   = busy_reg;
        level_next  = level_reg;
        va_next     = va_reg;
        entry.op    = OP_UNEXPECTED;
        entry.level = level_reg;
        entry.base  = read_data[PA_W-1:12];
        entry.va    = va_reg;
        if (mode == MODE_REQUEST)
        begin
            if (!busy_reg)
            begin
                entry.op    = OP_READ;
                entry.level = LEVEL_TOP;
                entry.base  = table_root[PA_W-1:12];
                entry.va    = virt_addr;
                busy_next   = 1'b1;
                level_next  = LEVEL_TOP;
                va_next     = virt_addr;
            end
        end
        else if (busy_reg)
        begin
            busy_next  = 1'b0;
            level_next = LEVEL_TOP;
            if (!read_ok)
                entry.op = OP_READ_FAIL;
            else if (!present)
                entry.op = OP_NOT_PRESENT;
            else if (level_reg == LEVEL_1G && huge_page)
                entry.op = OP_DONE_1G;
            else if (level_reg == LEVEL_2M && huge_page)
                entry.op = OP_DONE_2M;
            else if (level_reg == LEVEL_LAST)
                entry.op = OP_DONE_4K;
            else
            begin
                entry.op    = OP_READ;
                entry.level = level_reg + 2'd1;
                busy_next   = 1'b1;
                level_next  = level_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            level_reg <= LEVEL_TOP;
            va_reg    <= '0;
        end
        else if (accept)
        begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            va_reg    <= va_next;
        end
    end

endmodule

// File: src/wlk_queue.sv
module wlk_queue
    import wlk_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_entry,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output qent_t head_entry
);

    qent_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] ptr);
        logic [QPTR_W-1:0] res;
        res = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
        return res;
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: src/wlk_back.sv
module wlk_back
    import wlk_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  qent_t           head_entry,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            kind,
    output logic [PA_W-1:0] address,
    output logic [1:0]      status
);

    logic            valid_reg;
    logic            kind_reg;
    logic            kind_next;
    logic [PA_W-1:0] address_reg;
    logic [PA_W-1:0] address_next;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;

    // Take the head word whenever the output register is empty or draining.
    assign pop = head_valid && (!valid_reg || !out_stall);

    always_comb
    begin
        kind_next    = KIND_DONE;
        address_next = '0;
        status_next  = ST_UNEXPECTED;
        unique case (head_entry.op)
            OP_READ:
            begin
                kind_next    = KIND_READ;
                address_next = {head_entry.base,
                                level_index(head_entry.va, head_entry.level), 3'b000};
                status_next  = ST_OK;
            end
            OP_DONE_1G:
            begin
                address_next = {head_entry.base[BASE_W-1:18], head_entry.va[29:0]};
                status_next  = ST_OK;
            end
            OP_DONE_2M:
            begin
                address_next = {head_entry.base[BASE_W-1:9], head_entry.va[20:0]};
                status_next  = ST_OK;
            end
            OP_DONE_4K:
            begin
                address_next = {head_entry.base, head_entry.va[11:0]};
                status_next  = ST_OK;
            end
            OP_NOT_PRESENT: status_next = ST_NOT_PRESENT;
            OP_READ_FAIL:   status_next = ST_READ_FAIL;
            OP_UNEXPECTED:  status_next = ST_UNEXPECTED;
            default:        status_next = ST_UNEXPECTED;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg    <= kind_next;
            address_reg <= address_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign address   = address_reg;
    assign status    = status_reg;

endmodule

// File: src/four_level_page_walker_core.sv
// Four-level page table walker, 4 KiB granule, 48-bit virtual addresses.
//
// Input channel (in_valid / in_stall): each word is either a translate
// request (mode 0: virt_addr, table_root) or a memory read response
// (mode 1: read_data, read_ok). Output channel (out_valid / out_stall):
// exactly one word per input word, in order: a memory read request
// (kind 0, address of the entry) or a finished walk (kind 1, physical
// address and status; address is 0 unless status is ok).
//
// An accepted word goes into a queue slot and then into the output
// register before it shows on the output port. One word is accepted
// every cycle while a queue slot is free: the front classifies the word
// against the walk state in its accept cycle, a two-word queue holds
// classified words, and the back forms the address in an output register.
// When the receiver stalls, the output register holds, the queue fills,
// and in_stall rises once both queue slots are taken.
//
// Reset (rst_n, asynchronous, active low) leaves the walker idle with an
// empty queue and no result pending.
module four_level_page_walker_core
    import wlk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              mode,
    input  logic [VA_W-1:0]   virt_addr,
    input  logic [PA_W-1:0]   table_root,
    input  logic [DATA_W-1:0] read_data,
    input  logic              read_ok,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              kind,
    output logic [PA_W-1:0]   address,
    output logic [1:0]        status
);

    logic  accept;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    qent_t front_entry;
    qent_t head_entry;

    // Stall only when both queue slots are taken.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    wlk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (mode),
        .virt_addr  (virt_addr),
        .table_root (table_root),
        .read_data  (read_data),
        .read_ok    (read_ok),
        .entry      (front_entry)
    );

    wlk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    wlk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .address    (address),
        .status     (status)
    );

`ifndef SYNTHESIS
    // A full queue means the output register is holding a stalled word.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("queue full while output register is empty");

    // A queued word with an empty output register moves out the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !out_valid) |=> out_valid)
        else $error("back did not drain the queue");

    // A failed walk is formed as a finished walk with a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (kind == KIND_DONE && address == '0))
        else $error("failed walk carries an address or a read kind");
`endif

endmodule
